// File: design/sscl_pkg.sv
// Shared types, widths and register codes for the spring strain limit block.
package sscl_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int MAX_VERTICES_DEF = 4096;
  localparam int VIDX_W           = 12;
  localparam int POS_W            = 32;
  localparam int REST_W           = 31;
  localparam int FORCE_W          = 48;
  localparam int AD_W             = POS_W + 1;
  localparam int LEN_W            = POS_W + 1;
  localparam int RAD_W            = 2 * LEN_W;
  localparam int THR_W            = REST_W + 1;
  localparam int U_W              = FRAC_BITS + 1;
  localparam int SHARE_W          = 32;
  localparam int IH2_W            = 32;
  localparam int SL_W             = 16;
  localparam int SQRT_STAGES      = LEN_W;
  localparam int DIV_STAGES       = U_W;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_A       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_B       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_H2    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd3;

  // Register reset values
  localparam logic [VIDX_W-1:0] FIXED_A_RST       = 12'd0;
  localparam logic [VIDX_W-1:0] FIXED_B_RST       = 12'd49;
  localparam logic [IH2_W-1:0]  INVERSE_H2_RST    = 32'd2621440000;
  localparam logic [SL_W-1:0]   STRETCH_LIMIT_RST = 16'd6554;

  localparam logic [FORCE_W-2:0] FORCE_MAX = {(FORCE_W-1){1'b1}};
  localparam logic [U_W-1:0]     U_ONE     = U_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [VIDX_W-1:0]       first_vertex;
    logic [VIDX_W-1:0]       second_vertex;
    logic signed [POS_W-1:0] first_pos_x;
    logic signed [POS_W-1:0] first_pos_y;
    logic signed [POS_W-1:0] first_pos_z;
    logic signed [POS_W-1:0] second_pos_x;
    logic signed [POS_W-1:0] second_pos_y;
    logic signed [POS_W-1:0] second_pos_z;
    logic [REST_W-1:0]       rest_length;
    logic                    is_structural;
  } in_t;

  typedef struct packed {
    logic [VIDX_W-1:0]         first_target;
    logic [VIDX_W-1:0]         second_target;
    logic                      first_apply;
    logic                      second_apply;
    logic signed [FORCE_W-1:0] first_force_x;
    logic signed [FORCE_W-1:0] first_force_y;
    logic signed [FORCE_W-1:0] first_force_z;
    logic signed [FORCE_W-1:0] second_force_x;
    logic signed [FORCE_W-1:0] second_force_y;
    logic signed [FORCE_W-1:0] second_force_z;
  } out_t;

  // Sideband carried through the square root pipeline
  typedef struct packed {
    logic [VIDX_W-1:0]      v1;
    logic [VIDX_W-1:0]      v2;
    logic                   p1;
    logic                   p2;
    logic                   structural;
    logic [THR_W-1:0]       thr;
    logic [2:0][AD_W-1:0]   ad;
    logic [2:0]             neg;
  } sq_side_t;

  // Sideband carried through the divider pipeline and the multiply stages
  typedef struct packed {
    logic [VIDX_W-1:0] v1;
    logic [VIDX_W-1:0] v2;
    logic              p1;
    logic              p2;
    logic              over;
    logic [LEN_W-1:0]  excess;
    logic [2:0]        neg;
  } dv_side_t;

endpackage

// File: design/sscl_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module sscl_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [sscl_pkg::RAD_W-1:0]    in_rad,
  input  sscl_pkg::sq_side_t            in_side,
  output logic                          out_valid,
  output logic [sscl_pkg::LEN_W-1:0]    out_root,
  output sscl_pkg::sq_side_t            out_side
);

  localparam int N   = sscl_pkg::SQRT_STAGES;
  localparam int RW  = sscl_pkg::RAD_W;
  localparam int LW  = sscl_pkg::LEN_W;
  localparam int REM_W = LW + 1;
  localparam int ACC_W = LW + 3;

  logic                vld_r  [N];
  logic [RW-1:0]       rad_r  [N];
  logic [REM_W-1:0]    rem_r  [N];
  logic [LW-1:0]       root_r [N];
  sscl_pkg::sq_side_t  side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic               vld_c;
    logic [RW-1:0]      rad_c;
    logic [REM_W-1:0]   rem_c;
    logic [LW-1:0]      root_c;
    sscl_pkg::sq_side_t side_c;
    logic [ACC_W-1:0]   acc_c;
    logic [ACC_W-1:0]   trial_c;
    logic [RW-1:0]      rad_nxt;
    logic [REM_W-1:0]   rem_nxt;
    logic [LW-1:0]      root_nxt;

    // Select the stage source
    if (k == 0) begin : g_first
      assign vld_c  = in_valid;
      assign rad_c  = in_rad;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = in_side;
    end else begin : g_next
      assign vld_c  = vld_r[k-1];
      assign rad_c  = rad_r[k-1];
      assign rem_c  = rem_r[k-1];
      assign root_c = root_r[k-1];
      assign side_c = side_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      acc_c   = {rem_c, rad_c[RW-1 -: 2]};
      trial_c = {1'b0, root_c, 2'b01};
      rad_nxt = {rad_c[RW-3:0], 2'b00};
      if (acc_c >= trial_c) begin
        rem_nxt  = REM_W'(acc_c - trial_c);
        root_nxt = {root_c[LW-2:0], 1'b1};
      end else begin
        rem_nxt  = acc_c[REM_W-1:0];
        root_nxt = {root_c[LW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_c;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: design/sscl_div.sv
// Pipelined three-lane restoring divider for the unit direction.
module sscl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][sscl_pkg::AD_W-1:0]      in_ad,
  input  logic [sscl_pkg::LEN_W-1:0]          in_len,
  input  sscl_pkg::dv_side_t                  in_side,
  output logic                                out_valid,
  output logic [2:0][sscl_pkg::U_W-1:0]       out_u,
  output sscl_pkg::dv_side_t                  out_side
);

  localparam int N  = sscl_pkg::DIV_STAGES;
  localparam int LW = sscl_pkg::LEN_W;
  localparam int QW = sscl_pkg::U_W;
  localparam int AW = sscl_pkg::AD_W;

  logic                   vld_r  [N];
  logic [2:0][LW-1:0]     rem_r  [N];
  logic [2:0][QW-1:0]     q_r    [N];
  logic [LW-1:0]          len_r  [N];
  sscl_pkg::dv_side_t     side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic               vld_c;
    logic [2:0][LW-1:0] rem_c;
    logic [2:0][QW-1:0] q_c;
    logic [2:0]         bit_c;
    logic [LW-1:0]      len_c;
    sscl_pkg::dv_side_t side_c;
    logic [2:0][LW-1:0] rem_nxt;
    logic [2:0][QW-1:0] q_nxt;
    logic [LW:0]        acc_c [3];

    // First stage starts from |d| >> 1 and brings down its low bit
    if (k == 0) begin : g_first
      assign vld_c  = in_valid;
      assign len_c  = in_len;
      assign side_c = in_side;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_c[i] = {1'b0, in_ad[i][AW-1:1]};
        assign bit_c[i] = in_ad[i][0];
        assign q_c[i]   = '0;
      end
    end else begin : g_next
      assign vld_c  = vld_r[k-1];
      assign len_c  = len_r[k-1];
      assign side_c = side_r[k-1];
      assign rem_c  = rem_r[k-1];
      assign q_c    = q_r[k-1];
      assign bit_c  = '0;
    end

    // Shift in one dividend bit per lane and subtract where it fits
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        acc_c[i] = {rem_c[i], bit_c[i]};
        if (acc_c[i] >= {1'b0, len_c}) begin
          rem_nxt[i] = LW'(acc_c[i] - {1'b0, len_c});
          q_nxt[i]   = {q_c[i][QW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = acc_c[i][LW-1:0];
          q_nxt[i]   = {q_c[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        len_r[k]  <= len_c;
        side_r[k] <= side_c;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_u     = q_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: design/spring_strain_limit_correction_top.sv
// Top level of the spring strain limit correction pipeline.
// Stages from input transaction to out_valid: 3 front stages,
// 33-stage square root, 17-stage divider, 3 multiply and output stages.
// Throughput: one spring per cycle; a stalled output freezes the whole pipe.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// register defaults; payload registers are not reset.
module spring_strain_limit_correction_top #(
  parameter int MAX_VERTICES = sscl_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sscl_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sscl_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [sscl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sscl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int VW  = sscl_pkg::VIDX_W;
  localparam int AW  = sscl_pkg::AD_W;
  localparam int LW  = sscl_pkg::LEN_W;
  localparam int RW  = sscl_pkg::RAD_W;
  localparam int TW  = sscl_pkg::THR_W;
  localparam int UW  = sscl_pkg::U_W;
  localparam int SW  = sscl_pkg::SHARE_W;
  localparam int FW  = sscl_pkg::FORCE_W;
  localparam int FB  = sscl_pkg::FRAC_BITS;
  localparam int PW  = sscl_pkg::POS_W;
  localparam int RSW = sscl_pkg::REST_W;
  localparam int SLW = sscl_pkg::SL_W;
  localparam int IHW = sscl_pkg::IH2_W;
  localparam logic [VW-1:0] VMASK = VW'(MAX_VERTICES - 1);

  // Configuration registers
  logic [VW-1:0]  fixed_a_r, fixed_b_r;
  logic [IHW-1:0] inverse_h2_r;
  logic [SLW-1:0] stretch_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_a_r       <= sscl_pkg::FIXED_A_RST;
      fixed_b_r       <= sscl_pkg::FIXED_B_RST;
      inverse_h2_r    <= sscl_pkg::INVERSE_H2_RST;
      stretch_limit_r <= sscl_pkg::STRETCH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sscl_pkg::CFG_FIXED_A:       fixed_a_r       <= cfg_data[VW-1:0];
        sscl_pkg::CFG_FIXED_B:       fixed_b_r       <= cfg_data[VW-1:0];
        sscl_pkg::CFG_INVERSE_H2:    inverse_h2_r    <= cfg_data[IHW-1:0];
        sscl_pkg::CFG_STRETCH_LIMIT: stretch_limit_r <= cfg_data[SLW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output slot is free or taken
  logic en;
  logic out_valid_r;
  sscl_pkg::out_t out_data_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: differences, magnitudes, slack, pinned test
  logic signed [AW-1:0] d_c [3];
  logic [AW-1:0]        ad_c [3];
  logic [PW-1:0]        pa_c [3];
  logic [PW-1:0]        pb_c [3];
  logic [SLW+RSW-1:0]   slack_prod_c;
  logic [VW-1:0]        m1_c, m2_c, fa_c, fb_c;

  logic                 s1_vld_r;
  logic [VW-1:0]        s1_v1_r, s1_v2_r;
  logic                 s1_p1_r, s1_p2_r, s1_struct_r;
  logic [RSW-1:0]       s1_rest_r, s1_slack_r;
  logic [2:0][AW-1:0]   s1_ad_r;
  logic [2:0]           s1_neg_r;

  always_comb begin
    pa_c[0] = in_data.first_pos_x;
    pa_c[1] = in_data.first_pos_y;
    pa_c[2] = in_data.first_pos_z;
    pb_c[0] = in_data.second_pos_x;
    pb_c[1] = in_data.second_pos_y;
    pb_c[2] = in_data.second_pos_z;
    for (int i = 0; i < 3; i++) begin
      d_c[i]  = $signed({pa_c[i][PW-1], pa_c[i]}) - $signed({pb_c[i][PW-1], pb_c[i]});
      ad_c[i] = d_c[i][AW-1] ? AW'(-d_c[i]) : AW'(d_c[i]);
    end
    slack_prod_c = (SLW+RSW)'(stretch_limit_r) * (SLW+RSW)'(in_data.rest_length);
    m1_c = in_data.first_vertex & VMASK;
    m2_c = in_data.second_vertex & VMASK;
    fa_c = fixed_a_r & VMASK;
    fb_c = fixed_b_r & VMASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v1_r     <= in_data.first_vertex;
      s1_v2_r     <= in_data.second_vertex;
      s1_p1_r     <= (m1_c == fa_c) || (m1_c == fb_c);
      s1_p2_r     <= (m2_c == fa_c) || (m2_c == fb_c);
      s1_struct_r <= in_data.is_structural;
      s1_rest_r   <= in_data.rest_length;
      s1_slack_r  <= slack_prod_c[SLW+RSW-1:FB];
      for (int i = 0; i < 3; i++) begin
        s1_ad_r[i]  <= ad_c[i];
        s1_neg_r[i] <= d_c[i][AW-1];
      end
    end
  end

  // Stage 2: squares and threshold
  logic               s2_vld_r;
  logic [RW-1:0]      s2_sq_r [3];
  sscl_pkg::sq_side_t s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i] <= RW'(s1_ad_r[i]) * RW'(s1_ad_r[i]);
      end
      s2_side_r.v1         <= s1_v1_r;
      s2_side_r.v2         <= s1_v2_r;
      s2_side_r.p1         <= s1_p1_r;
      s2_side_r.p2         <= s1_p2_r;
      s2_side_r.structural <= s1_struct_r;
      s2_side_r.thr        <= TW'(s1_rest_r) + TW'(s1_slack_r);
      s2_side_r.ad         <= s1_ad_r;
      s2_side_r.neg        <= s1_neg_r;
    end
  end

  // Stage 3: sum of squares
  logic               s3_vld_r;
  logic [RW-1:0]      s3_rad_r;
  sscl_pkg::sq_side_t s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad_r  <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
      s3_side_r <= s2_side_r;
    end
  end

  // Square root of the squared length
  logic               sq_vld;
  logic [LW-1:0]      sq_len;
  sscl_pkg::sq_side_t sq_side;

  sscl_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_rad_r),
    .in_side   (s3_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_len),
    .out_side  (sq_side)
  );

  // Overstretch test and excess beside the divider entry
  sscl_pkg::dv_side_t dv_in_side;

  always_comb begin
    dv_in_side.v1     = sq_side.v1;
    dv_in_side.v2     = sq_side.v2;
    dv_in_side.p1     = sq_side.p1;
    dv_in_side.p2     = sq_side.p2;
    dv_in_side.over   = sq_side.structural && (sq_len > LW'(sq_side.thr));
    dv_in_side.excess = sq_len - LW'(sq_side.thr);
    dv_in_side.neg    = sq_side.neg;
  end

  logic               dv_vld;
  logic [2:0][UW-1:0] dv_u;
  sscl_pkg::dv_side_t dv_side;

  sscl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_ad     (sq_side.ad),
    .in_len    (sq_len),
    .in_side   (dv_in_side),
    .out_valid (dv_vld),
    .out_u     (dv_u),
    .out_side  (dv_side)
  );

  // Multiply 1: half excess along each direction component
  logic [UW-1:0]      u_clamp_c [3];
  logic [LW+UW-1:0]   share_prod_c [3];
  logic               m1_vld_r;
  logic [SW-1:0]      m1_share_r [3];
  sscl_pkg::dv_side_t m1_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_clamp_c[i]    = (dv_u[i] > sscl_pkg::U_ONE) ? sscl_pkg::U_ONE : dv_u[i];
      share_prod_c[i] = (LW+UW)'(dv_side.excess) * (LW+UW)'(u_clamp_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_share_r[i] <= SW'(share_prod_c[i] >> (FB + 1));
      end
      m1_side_r <= dv_side;
    end
  end

  // Multiply 2: scale by the inverse squared time step
  logic [SW+IHW-1:0]  mag_prod_c [3];
  logic               m2_vld_r;
  logic [FW-1:0]      m2_mag_r [3];
  sscl_pkg::dv_side_t m2_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_prod_c[i] = (SW+IHW)'(m1_share_r[i]) * (SW+IHW)'(inverse_h2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m2_mag_r[i] <= FW'(mag_prod_c[i] >> FB);
      end
      m2_side_r <= m1_side_r;
    end
  end

  // Output stage: double for a lone free end, saturate, sign and route
  logic                 act_c, apply1_c, apply2_c;
  logic [FW:0]          dbl_c [3];
  logic [FW-1:0]        sat_c [3];
  logic signed [FW-1:0] f_c [3];
  logic signed [FW-1:0] first_f_c [3];
  logic signed [FW-1:0] second_f_c [3];
  sscl_pkg::out_t       out_nxt;

  always_comb begin
    act_c    = m2_side_r.over && !(m2_side_r.p1 && m2_side_r.p2);
    apply1_c = act_c && !m2_side_r.p1;
    apply2_c = act_c && !m2_side_r.p2;
    for (int i = 0; i < 3; i++) begin
      dbl_c[i] = (m2_side_r.p1 || m2_side_r.p2) ? {m2_mag_r[i], 1'b0}
                                                 : {1'b0, m2_mag_r[i]};
      sat_c[i] = (dbl_c[i] > (FW+1)'(sscl_pkg::FORCE_MAX))
               ? FW'(sscl_pkg::FORCE_MAX) : dbl_c[i][FW-1:0];
      f_c[i]   = m2_side_r.neg[i] ? -$signed(sat_c[i]) : $signed(sat_c[i]);
      first_f_c[i]  = apply1_c ? -f_c[i] : '0;
      second_f_c[i] = apply2_c ? f_c[i] : '0;
    end
    out_nxt.first_target   = m2_side_r.v1;
    out_nxt.second_target  = m2_side_r.v2;
    out_nxt.first_apply    = apply1_c;
    out_nxt.second_apply   = apply2_c;
    out_nxt.first_force_x  = first_f_c[0];
    out_nxt.first_force_y  = first_f_c[1];
    out_nxt.first_force_z  = first_f_c[2];
    out_nxt.second_force_x = second_f_c[0];
    out_nxt.second_force_y = second_f_c[1];
    out_nxt.second_force_z = second_f_c[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/sscl_checker.sv
// Port-level checks for the spring strain limit correction top level.
module sscl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input sscl_pkg::out_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Accept input whenever the output slot can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output slot");

  // Drop the first force when it is not applied
  a_zero_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.first_apply |->
      out_data.first_force_x == 0 && out_data.first_force_y == 0 &&
      out_data.first_force_z == 0)
    else $error("unapplied first force is nonzero");

  // Two free ends receive opposite x and z forces
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.first_apply && out_data.second_apply |->
      out_data.first_force_x == -out_data.second_force_x &&
      out_data.first_force_z == -out_data.second_force_z)
    else $error("free-end forces not balanced");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spring_strain_limit_correction_top sscl_checker u_sscl_checker (.*);

// File: sim/spring_strain_limit_correction_top_tb.sv
// Self-checking testbench for the spring strain limit correction pipeline.
module spring_strain_limit_correction_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT    = 56;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sscl_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sscl_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [sscl_pkg::CFG_IDX_W-1:0] cfg_index = sscl_pkg::CFG_FIXED_A;
  logic [sscl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block's registers
  logic [sscl_pkg::VIDX_W-1:0] pin_a = sscl_pkg::FIXED_A_RST;
  logic [sscl_pkg::VIDX_W-1:0] pin_b = sscl_pkg::FIXED_B_RST;
  logic [sscl_pkg::IH2_W-1:0] inv_h2 = sscl_pkg::INVERSE_H2_RST;
  logic [sscl_pkg::SL_W-1:0] stretch_lim = sscl_pkg::STRETCH_LIMIT_RST;

  sscl_pkg::out_t expected_corrections[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  spring_strain_limit_correction_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Per-axis distance, magnitude and length of one spring
  function automatic void spring_geometry(input sscl_pkg::in_t s,
                                          output logic [63:0] len,
                                          output logic [2:0][32:0] ad,
                                          output logic [2:0] neg);
    logic signed [32:0] d;
    logic [71:0] sum;
    logic [63:0] r;
    logic [63:0] c;
    logic signed [32:0] p1[3];
    logic signed [32:0] p2[3];
    p1[0] = 33'(s.first_pos_x);  p1[1] = 33'(s.first_pos_y);  p1[2] = 33'(s.first_pos_z);
    p2[0] = 33'(s.second_pos_x); p2[1] = 33'(s.second_pos_y); p2[2] = 33'(s.second_pos_z);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = p1[i] - p2[i];
      neg[i] = d[32];
      ad[i] = d[32] ? 33'(-d) : 33'(d);
      sum = sum + 72'(ad[i]) * 72'(ad[i]);
    end
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (72'(c) * 72'(c) <= sum) r = c;
    end
    len = r;
  endfunction

  // Expected correction for one spring under the current registers
  function automatic sscl_pkg::out_t predict_correction(input sscl_pkg::in_t s);
    sscl_pkg::out_t o;
    logic [63:0] len, slack, excess, u, share, mag, f;
    logic [2:0][32:0] ad;
    logic [2:0] neg;
    logic pin1, pin2;
    o = '0;
    o.first_target = s.first_vertex;
    o.second_target = s.second_vertex;
    spring_geometry(s, len, ad, neg);
    slack = (64'(stretch_lim) * 64'(s.rest_length)) >> 16;
    pin1 = (s.first_vertex == pin_a) || (s.first_vertex == pin_b);
    pin2 = (s.second_vertex == pin_a) || (s.second_vertex == pin_b);
    if (s.is_structural && len > 64'(s.rest_length) + slack && !(pin1 && pin2)) begin
      excess = len - 64'(s.rest_length) - slack;
      for (int i = 0; i < 3; i++) begin
        u = (64'(ad[i]) << 16) / len;
        if (u > 64'd65536) u = 64'd65536;
        share = (excess * u) >> 17;
        mag = (share * 64'(inv_h2)) >> 16;
        if (pin1 || pin2) mag = mag << 1;
        if (mag > 64'(sscl_pkg::FORCE_MAX)) mag = 64'(sscl_pkg::FORCE_MAX);
        f = neg[i] ? -mag : mag;
        if (!pin1) begin
          case (i)
            0: o.first_force_x = 48'(-f);
            1: o.first_force_y = 48'(-f);
            default: o.first_force_z = 48'(-f);
          endcase
        end
        if (!pin2) begin
          case (i)
            0: o.second_force_x = 48'(f);
            1: o.second_force_y = 48'(f);
            default: o.second_force_z = 48'(f);
          endcase
        end
      end
      o.first_apply = !pin1;
      o.second_apply = !pin2;
    end
    return o;
  endfunction

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Record accepted springs and check accepted corrections
  always @(posedge clk) begin
    sscl_pkg::out_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("spring_strain_limit_correction_top_tb: FAIL");
      $finish;
    end
    if (rst_n && in_valid && in_ready)
      expected_corrections.insert(expected_corrections.size(),
                                  predict_correction(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_corrections.size() == 0) begin
        $error("unexpected correction transaction");
        fail_count++;
      end else begin
        e = expected_corrections.pop_front();
        report_field("first_target", 64'(e.first_target), 64'(out_data.first_target));
        report_field("second_target", 64'(e.second_target), 64'(out_data.second_target));
        report_field("first_apply", 64'(e.first_apply), 64'(out_data.first_apply));
        report_field("second_apply", 64'(e.second_apply), 64'(out_data.second_apply));
        report_field("first_force_x", 64'(e.first_force_x), 64'(out_data.first_force_x));
        report_field("first_force_y", 64'(e.first_force_y), 64'(out_data.first_force_y));
        report_field("first_force_z", 64'(e.first_force_z), 64'(out_data.first_force_z));
        report_field("second_force_x", 64'(e.second_force_x),
                     64'(out_data.second_force_x));
        report_field("second_force_y", 64'(e.second_force_y),
                     64'(out_data.second_force_y));
        report_field("second_force_z", 64'(e.second_force_z),
                     64'(out_data.second_force_z));
      end
    end
  end

  // Randomly stall the result side
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Send one spring; entered and left at a falling edge
  task automatic send_spring(input sscl_pkg::in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold until every correction has arrived, then let the pipe empty
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_corrections.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sscl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sscl_pkg::CFG_FIXED_A: pin_a = val[sscl_pkg::VIDX_W-1:0];
      sscl_pkg::CFG_FIXED_B: pin_b = val[sscl_pkg::VIDX_W-1:0];
      sscl_pkg::CFG_INVERSE_H2: inv_h2 = val;
      default: stretch_lim = val[sscl_pkg::SL_W-1:0];
    endcase
  endtask

  function automatic logic [31:0] rand_coord(input int scale);
    case (scale)
      0: return 32'($signed($urandom_range(8191)) - 4096);
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: return 32'($signed($urandom_range(536870911)) - 268435456);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sscl_pkg::VIDX_W-1:0] rand_vertex();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return pin_a;
    if (pick == 1) return pin_b;
    return sscl_pkg::VIDX_W'($urandom);
  endfunction

  // Random spring, mostly structural, rest length mostly up to 1.2 times its length
  function automatic sscl_pkg::in_t random_spring();
    sscl_pkg::in_t s;
    logic [63:0] len;
    logic [2:0][32:0] ad;
    logic [2:0] neg;
    int scale;
    scale = $urandom_range(3);
    s.first_vertex = rand_vertex();
    s.second_vertex = rand_vertex();
    s.first_pos_x = rand_coord(scale);
    s.first_pos_y = rand_coord(scale);
    s.first_pos_z = rand_coord(scale);
    s.second_pos_x = rand_coord(scale);
    s.second_pos_y = rand_coord(scale);
    s.second_pos_z = rand_coord(scale);
    s.is_structural = ($urandom_range(99) < 85);
    spring_geometry(s, len, ad, neg);
    if ($urandom_range(9) == 0)
      s.rest_length = sscl_pkg::REST_W'($urandom);
    else begin
      len = (len * 64'($urandom_range(1200))) / 64'd1000;
      s.rest_length = (len > 64'h7FFF_FFFF) ? sscl_pkg::REST_W'(32'h7FFF_FFFF)
                                            : sscl_pkg::REST_W'(len);
    end
    return s;
  endfunction

  task automatic random_batch(input int count);
    for (int n = 0; n < count; n++) send_spring(random_spring());
  endtask

  function automatic sscl_pkg::in_t make_spring(input logic [sscl_pkg::VIDX_W-1:0] v1, v2,
                                                input logic [31:0] ax, ay, az, bx, by, bz,
                                                input logic [sscl_pkg::REST_W-1:0] rest,
                                                input logic structural);
    sscl_pkg::in_t s;
    s.first_vertex = v1;   s.second_vertex = v2;
    s.first_pos_x = ax;    s.first_pos_y = ay;   s.first_pos_z = az;
    s.second_pos_x = bx;   s.second_pos_y = by;  s.second_pos_z = bz;
    s.rest_length = rest;  s.is_structural = structural;
    return s;
  endfunction

  // Corner springs under reset registers
  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_spring(make_spring(12'd5, 12'd6, 32'h10000, 0, 0, 0, 0, 0, 31'h8000, 1'b1));
    send_spring(make_spring(12'd5, 12'd6, 0, 0, 0, 32'h10000, 0, 0, 31'h8000, 1'b1));
    send_spring(make_spring(12'd5, 12'd6, 32'h10000, 0, 0, 0, 0, 0, 31'h8000, 1'b0));
    send_spring(make_spring(12'd5, 12'd6, 32'h10000, 0, 0, 0, 0, 0, 31'h10000, 1'b1));
    send_spring(make_spring(12'd0, 12'd49, 32'h10000, 0, 0, 0, 0, 0, 31'h100, 1'b1));
    send_spring(make_spring(12'd49, 12'd7, 32'h30000, 32'h20000, 32'h10000, 0, 0, 0,
                            31'h100, 1'b1));
    send_spring(make_spring(12'd7, 12'd0, 32'h30000, 32'hFFFE0000, 32'h10000, 0, 0, 0,
                            31'h100, 1'b1));
    send_spring(make_spring(12'd0, 12'd0, 32'h30000, 0, 0, 0, 0, 0, 31'h100, 1'b1));
    send_spring(make_spring(12'd9, 12'd9, 32'h30000, 0, 0, 0, 0, 0, 31'h100, 1'b1));
    send_spring(make_spring(12'd1, 12'd2, 32'h1234, 32'h55, 32'h9, 32'h1234, 32'h55, 32'h9,
                            31'd0, 1'b1));
    send_spring(make_spring(12'hFFF, 12'hFFE, mx, mx, mx, mn, mn, mn, 31'd0, 1'b1));
    send_spring(make_spring(12'hFFF, 12'hFFE, mn, mn, mn, mx, mx, mx, 31'd0, 1'b1));
    send_spring(make_spring(12'hFFF, 12'd1, mx, mn, mx, mn, mx, mn, 31'h7FFF_FFFF, 1'b1));
    send_spring(make_spring(12'd3, 12'hFFF, mx, 0, 0, mn, 0, 0, 31'h7FFF_FFFF, 1'b1));
    send_spring(make_spring(12'd3, 12'd4, 0, 32'h1, 0, 0, 0, 0, 31'd0, 1'b1));
    send_spring(make_spring(12'd3, 12'd4, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 31'd0, 1'b1));
    drain_pipe();
  endtask

  // Walk the registers through several settings, extremes included
  task automatic test_register_settings();
    write_reg(sscl_pkg::CFG_FIXED_A, 32'hFFF);
    write_reg(sscl_pkg::CFG_FIXED_B, 32'd0);
    write_reg(sscl_pkg::CFG_INVERSE_H2, 32'hFFFF_FFFF);
    write_reg(sscl_pkg::CFG_STRETCH_LIMIT, 32'hFFFF);
    random_batch(60);
    drain_pipe();
    write_reg(sscl_pkg::CFG_INVERSE_H2, 32'd0);
    write_reg(sscl_pkg::CFG_STRETCH_LIMIT, 32'd0);
    write_reg(sscl_pkg::CFG_FIXED_A, 32'd100);
    write_reg(sscl_pkg::CFG_FIXED_B, 32'd100);
    random_batch(60);
    drain_pipe();
    write_reg(sscl_pkg::CFG_INVERSE_H2, 32'h0001_0000);
    write_reg(sscl_pkg::CFG_STRETCH_LIMIT, 32'd1);
    write_reg(sscl_pkg::CFG_FIXED_A, $urandom);
    write_reg(sscl_pkg::CFG_FIXED_B, $urandom);
    random_batch(60);
    drain_pipe();
    write_reg(sscl_pkg::CFG_FIXED_A, 32'(sscl_pkg::FIXED_A_RST));
    write_reg(sscl_pkg::CFG_FIXED_B, 32'(sscl_pkg::FIXED_B_RST));
    write_reg(sscl_pkg::CFG_INVERSE_H2, 32'(sscl_pkg::INVERSE_H2_RST));
    write_reg(sscl_pkg::CFG_STRETCH_LIMIT, 32'(sscl_pkg::STRETCH_LIMIT_RST));
  endtask

  // Random springs under each mix of sender gaps and receiver stalls
  task automatic test_flow_control();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_batch(420);
    send_idle_pct = 46; recv_stall_pct = 0;  random_batch(200);
    drain_pipe();
    random_batch(200);
    send_idle_pct = 0;  recv_stall_pct = 46; random_batch(420);
    send_idle_pct = 26; recv_stall_pct = 26; random_batch(420);
    send_idle_pct = 0;  recv_stall_pct = 0;
    drain_pipe();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_register_settings();
    test_flow_control();
    if (fail_count == 0)
      $display("spring_strain_limit_correction_top_tb: PASS");
    else
      $display("spring_strain_limit_correction_top_tb: FAIL");
    $finish;
  end

endmodule
